FILE: design/b2dd_pkg.sv
// Shared types, the digit width constant and a helper function for the binary to decimal digit converter.
package b2dd_pkg;

   localparam int DIGIT_W = 4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new value and clear the digit register
      logic conv_step;   // one double-dabble step on the next value bit
      logic digit_step;  // move the digit register up by one digit
      logic emit;        // place the top digit into the output register
      logic emit_last;   // the emitted digit is the final one
   } b2dd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // output register can take a digit this cycle
      logic top_nonzero; // top digit of the digit register is not zero
   } b2dd_status_type;

   // Add three to a digit of five or more, ahead of the doubling shift.
   function automatic logic [DIGIT_W-1:0] adjust_digit(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      r = d;
      if (d >= 4'd5) begin
         r = d + 4'd3;
      end
      return r;
   endfunction

endpackage

FILE: design/binary128_to_decimal_digits.sv
// Top level of the unsigned binary to decimal digit converter.
//
// A request beat carries an unsigned value as two 64-bit halves; only the
// low VALUE_BITS bits of the combined value are converted. Each response
// beat carries one decimal digit, most significant first, with
// rsp_last_digit set on the final digit. Leading zeros are suppressed, so a
// value of zero gives the single digit 0.
// The conversion is a shift-and-add-3 pass, one value bit per cycle, over a
// register of packed decimal digits. The digits then leave one per cycle
// while the receiver does not stall, the register moving up a digit each
// time; suppressed leading zeros are stepped past in the same way, without
// a beat. The block is occupied by the bit-serial conversion loop and the
// digit-serial output and takes no new value until both are through.
// req_stall is low only while the block is idle; a new request is taken even
// while the final digit of the previous value still waits in the output
// register. When rsp_stall is high while a beat is valid, the output register
// holds its beat and the digit sequence pauses. Reset returns the controller
// to idle and empties the output register.
module binary128_to_decimal_digits #(
   parameter int VALUE_BITS = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [63:0]                  req_value_high,
   input  logic [63:0]                  req_value_low,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [b2dd_pkg::DIGIT_W-1:0] rsp_digit,
   output logic                         rsp_last_digit
);
   import b2dd_pkg::*;

   // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1.
   localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

   b2dd_cmd_type    cmd;
   b2dd_status_type status;

   // The controller sequences load, conversion steps and digit output.
   b2dd_ctrl #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the value, the digit register and the output beat.
   b2dd_dp #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value_high (req_value_high),
      .req_value_low  (req_value_low),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

FILE: design/b2dd_ctrl.sv
// Controller state machine: sequences the conversion steps and the digit output.
module b2dd_ctrl #(
   parameter int VALUE_BITS = 128,
   parameter int NUM_DIGITS = 39
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  b2dd_pkg::b2dd_status_type status,
   output b2dd_pkg::b2dd_cmd_type    cmd
);
   import b2dd_pkg::*;

   localparam int BIT_CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DIG_CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   seen_ff, seen_in;
   logic                   last_pos;

   assign req_stall = (state_ff != ST_IDLE);
   assign last_pos  = (dig_cnt_ff == DIG_CNT_W'(NUM_DIGITS - 1));

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      seen_in    = seen_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS - 1);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = '0;
               seen_in    = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.digit_step = 1'b1;
               dig_cnt_in     = dig_cnt_ff + 1'b1;
               if (status.top_nonzero || seen_ff || last_pos) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = last_pos;
                  seen_in       = 1'b1;
               end
               if (last_pos) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      seen_ff    <= seen_in;
   end

endmodule

FILE: design/b2dd_dp.sv
// Datapath: value shift register, packed decimal digit register and output register.
module b2dd_dp #(
   parameter int VALUE_BITS = 128,
   parameter int NUM_DIGITS = 39
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [63:0]                       req_value_high,
   input  logic [63:0]                       req_value_low,
   input  b2dd_pkg::b2dd_cmd_type            cmd,
   output b2dd_pkg::b2dd_status_type         status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [b2dd_pkg::DIGIT_W-1:0]      rsp_digit,
   output logic                              rsp_last_digit
);
   import b2dd_pkg::*;

   localparam int BCD_W = NUM_DIGITS * DIGIT_W;

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      bcd_adj;
   logic [127:0]          full_value;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]    rsp_digit_ff, rsp_digit_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [DIGIT_W-1:0]    top_digit;

   assign full_value = {req_value_high, req_value_low};
   assign top_digit  = bcd_ff[BCD_W-1 -: DIGIT_W];

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i*DIGIT_W +: DIGIT_W] = adjust_digit(bcd_ff[i*DIGIT_W +: DIGIT_W]);
      end
   end

   always_comb begin
      value_in = value_ff;
      bcd_in   = bcd_ff;
      if (cmd.load) begin
         value_in = full_value[VALUE_BITS-1:0];
         bcd_in   = '0;
      end else if (cmd.conv_step) begin
         value_in = {value_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in   = {bcd_adj[BCD_W-2:0], value_ff[VALUE_BITS-1]};
      end else if (cmd.digit_step) begin
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign status.top_nonzero = (top_digit != '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_digit_in = top_digit;
         rsp_last_in  = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      bcd_ff       <= bcd_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule
